[hdl/bpsd_pkg.sv]
// ----------------------------------------------------------------------------
// bpsd_pkg
// Shared types and constants of the byte pair stream decoder.
// ----------------------------------------------------------------------------
package bpsd_pkg;

    localparam int STACK_DEPTH = 129;
    localparam int LEVEL_BITS  = 8;

    typedef enum logic [1:0] {
        FN_BYTE = 2'd0,
        FN_TICK = 2'd1,
        FN_EOF  = 2'd2,
        FN_NOP  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_TRUNC = 2'd1,
        ERR_REF   = 2'd2,
        ERR_BODY  = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        STK_HOLD,
        STK_POP,
        STK_PUSH
    } stk_op_t;

    // push_hi lands on top, push_lo just below it
    typedef struct packed {
        stk_op_t    op;
        logic [7:0] push_hi;
        logic [7:0] push_lo;
    } stk_ctl_t;

endpackage

[hdl/bpsd_if.sv]
// ----------------------------------------------------------------------------
// bpsd channel interfaces
// Valid/ready channels for items, results and the mode register write.
// ----------------------------------------------------------------------------
interface bpsd_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       file_start;

    modport source (output valid, func, data_byte, file_start, input ready);
    modport sink   (input valid, func, data_byte, file_start, output ready);
endinterface

interface bpsd_res_if;
    logic        valid;
    logic        ready;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        need_input;
    logic        done_res;
    logic [1:0]  error_code;
    logic [23:0] byte_count;

    modport source (output valid, out_valid, out_byte, need_input, done_res,
                    error_code, byte_count, input ready);
    modport sink   (input valid, out_valid, out_byte, need_input, done_res,
                    error_code, byte_count, output ready);
endinterface

interface bpsd_cfg_if;
    logic valid;
    logic ready;
    logic compressed_mode;

    modport source (output valid, compressed_mode, input ready);
    modport sink   (input valid, compressed_mode, output ready);
endinterface

[hdl/byte_pair_stream_decoder.sv]
// ----------------------------------------------------------------------------
// byte_pair_stream_decoder
// Byte pair encoding decompressor with a shifting cell stack for expansion.
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  cmd     | in  | valid/ready  | func, data_byte, file_start
//  res     | out | valid/ready  | out_valid, out_byte, need_input, done_res,
//          |     |              | error_code, byte_count
//  cfg     | in  | valid/ready  | compressed_mode (ready always high)
//
//  One item per cycle unless res.ready or a pair push stalls. The pair table
//  read is registered and the push into the cell row happens in the next cycle.
//  Each item gives exactly one result, held in an output register, so a new
//  item is taken while the previous result waits if res.ready is high.
//  Reset empties the stack, enters the expect-first-byte phase and sets
//  compressed mode. The pair table and stack cells are not cleared.
// ----------------------------------------------------------------------------
module byte_pair_stream_decoder #(
    parameter int MAX_PAIRS  = 128,
    parameter int COUNT_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    bpsd_cmd_if.sink    cmd,
    bpsd_res_if.source  res,
    bpsd_cfg_if.sink    cfg
);
    import bpsd_pkg::*;

    localparam int TBL_AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam logic [7:0] MAX_PAIRS_B = 8'(MAX_PAIRS);
    localparam logic [LEVEL_BITS-1:0] LEVEL_PUSH_MAX = LEVEL_BITS'(STACK_DEPTH - 2);

    typedef enum logic [2:0] {
        PH_FIRST     = 3'd0,
        PH_TABLE     = 3'd1,
        PH_BODY      = 3'd2,
        PH_DRAIN     = 3'd3,
        PH_DONE      = 3'd4,
        PH_ERR_TRUNC = 3'd5,
        PH_ERR_REF   = 3'd6,
        PH_ERR_BODY  = 3'd7
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [LEVEL_BITS-1:0]   level_reg, level_next;
    logic [6:0]              pc_reg, pc_next;
    logic [7:0]              fill_reg, fill_next;
    logic [7:0]              held_reg, held_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic                    mode_reg;
    logic                    pend_reg, pend_next;
    logic                    rvalid_reg;

    logic [7:0]  out_byte_reg;
    logic        out_valid_reg, need_reg, done_reg;
    err_t        err_reg, err_next;
    logic [23:0] bcount_reg;

    // values seen by the item after an optional file_start clear
    phase_t                ph_eff;
    logic [LEVEL_BITS-1:0] lvl_eff, lvl_base;
    logic [6:0]            pc_eff;
    logic [7:0]            fill_eff, fill_inc, held_eff, sym, ebyte;
    logic [COUNT_BITS-1:0] cnt_eff;
    logic                  opn, do_exp, do_emit, do_pop, push_go, is_tick;
    logic                  tbl_we;
    logic [15:0]           tbl_rdata;
    logic [7:0]            top_byte;
    logic                  acc;
    stk_ctl_t              stk_ctl;

    assign acc       = cmd.valid && cmd.ready;
    assign cmd.ready = !pend_reg && (!rvalid_reg || res.ready);
    assign cfg.ready = 1'b1;

    always_comb
    begin
        fill_inc = 8'h00;
        ph_eff   = cmd.file_start ? PH_FIRST : phase_reg;
        lvl_eff  = cmd.file_start ? '0 : level_reg;
        pc_eff   = cmd.file_start ? 7'd0 : pc_reg;
        fill_eff = cmd.file_start ? 8'd0 : fill_reg;
        held_eff = cmd.file_start ? 8'd0 : held_reg;
        cnt_eff  = cmd.file_start ? '0 : count_reg;
        opn      = (ph_eff == PH_FIRST) || (ph_eff == PH_TABLE) || (ph_eff == PH_BODY);

        phase_next = ph_eff;
        level_next = lvl_eff;
        pc_next    = pc_eff;
        fill_next  = fill_eff;
        held_next  = held_eff;
        count_next = cnt_eff;
        do_exp     = 1'b0;
        do_emit    = 1'b0;
        do_pop     = 1'b0;
        push_go    = 1'b0;
        tbl_we     = 1'b0;
        is_tick    = 1'b0;
        sym        = cmd.data_byte;
        ebyte      = cmd.data_byte;
        lvl_base   = lvl_eff;

        case (cmd.func)
            FN_BYTE:
            begin
                if (opn && lvl_eff == '0)
                begin
                    if (!mode_reg)
                    begin
                        do_emit    = 1'b1;
                        phase_next = PH_BODY;
                    end
                    else if (ph_eff == PH_FIRST)
                    begin
                        if (cmd.data_byte[7])
                        begin
                            if ({1'b0, cmd.data_byte[6:0]} > MAX_PAIRS_B)
                            begin
                                phase_next = PH_ERR_REF;
                                level_next = '0;
                            end
                            else
                            begin
                                pc_next    = cmd.data_byte[6:0];
                                fill_next  = 8'd0;
                                phase_next = (cmd.data_byte[6:0] == 7'd0) ? PH_BODY : PH_TABLE;
                            end
                        end
                        else
                        begin
                            phase_next = PH_BODY;
                            do_exp     = 1'b1;
                        end
                    end
                    else if (ph_eff == PH_TABLE)
                    begin
                        // a table byte may only name an earlier pair
                        if ({1'b0, cmd.data_byte} >= 9'd128 + {2'b00, fill_eff[7:1]})
                        begin
                            phase_next = PH_ERR_REF;
                            level_next = '0;
                        end
                        else
                        begin
                            if (!fill_eff[0])
                            begin
                                held_next = cmd.data_byte;
                            end
                            else
                            begin
                                tbl_we = 1'b1;
                            end
                            fill_inc  = fill_eff + 8'd1;
                            fill_next = fill_inc;
                            if (!fill_inc[0] && fill_inc[7:1] >= pc_eff)
                            begin
                                phase_next = PH_BODY;
                            end
                        end
                    end
                    else
                    begin
                        do_exp = 1'b1;
                    end
                end
            end
            FN_TICK:
            begin
                if ((opn || ph_eff == PH_DRAIN) && lvl_eff != '0)
                begin
                    is_tick    = 1'b1;
                    do_pop     = 1'b1;
                    do_exp     = 1'b1;
                    sym        = top_byte;
                    lvl_base   = lvl_eff - LEVEL_BITS'(1);
                    level_next = lvl_base;
                end
            end
            FN_EOF:
            begin
                if (opn)
                begin
                    if (ph_eff == PH_TABLE && mode_reg)
                    begin
                        phase_next = PH_ERR_TRUNC;
                        level_next = '0;
                    end
                    else
                    begin
                        phase_next = (lvl_eff == '0) ? PH_DONE : PH_DRAIN;
                    end
                end
            end
            default:
            begin
                phase_next = ph_eff;
            end
        endcase

        if (do_exp)
        begin
            if (!sym[7])
            begin
                do_emit = 1'b1;
                ebyte   = sym;
            end
            else if (sym[6:0] >= pc_eff || lvl_base > LEVEL_PUSH_MAX)
            begin
                phase_next = PH_ERR_BODY;
                level_next = '0;
            end
            else
            begin
                push_go    = 1'b1;
                level_next = lvl_base + LEVEL_BITS'(2);
            end
        end

        if (is_tick && phase_next == PH_DRAIN && level_next == '0)
        begin
            phase_next = PH_DONE;
        end

        if (do_emit && cnt_eff != '1)
        begin
            count_next = cnt_eff + COUNT_BITS'(1);
        end

        case (phase_next)
            PH_ERR_TRUNC: err_next = ERR_TRUNC;
            PH_ERR_REF:   err_next = ERR_REF;
            PH_ERR_BODY:  err_next = ERR_BODY;
            default:      err_next = ERR_NONE;
        endcase

        pend_next = acc && push_go;
    end

    always_comb
    begin
        stk_ctl.push_hi = tbl_rdata[15:8];
        stk_ctl.push_lo = tbl_rdata[7:0];
        if (pend_reg)
        begin
            stk_ctl.op = STK_PUSH;
        end
        else if (acc && do_pop)
        begin
            stk_ctl.op = STK_POP;
        end
        else
        begin
            stk_ctl.op = STK_HOLD;
        end
    end

    bpsd_stack u_stack (
        .clk (clk),
        .ctl (stk_ctl),
        .top (top_byte)
    );

    bpsd_pair_table #(
        .DEPTH (MAX_PAIRS),
        .AW    (TBL_AW)
    ) u_table (
        .clk   (clk),
        .we    (acc && tbl_we),
        .waddr (fill_eff[TBL_AW:1]),
        .wdata ({held_eff, cmd.data_byte}),
        .raddr (sym[TBL_AW-1:0]),
        .rdata (tbl_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FIRST;
            level_reg  <= '0;
            pc_reg     <= 7'd0;
            fill_reg   <= 8'd0;
            held_reg   <= 8'd0;
            count_reg  <= '0;
            mode_reg   <= 1'b1;
            pend_reg   <= 1'b0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                mode_reg <= cfg.compressed_mode;
            end
            pend_reg <= pend_next;
            if (acc)
            begin
                phase_reg  <= phase_next;
                level_reg  <= level_next;
                pc_reg     <= pc_next;
                fill_reg   <= fill_next;
                held_reg   <= held_next;
                count_reg  <= count_next;
                rvalid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                rvalid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            out_valid_reg <= do_emit;
            out_byte_reg  <= do_emit ? ebyte : 8'h00;
            need_reg      <= (level_next == '0) && ((phase_next == PH_FIRST) ||
                             (phase_next == PH_TABLE) || (phase_next == PH_BODY));
            done_reg      <= (phase_next >= PH_DONE);
            err_reg       <= err_next;
            bcount_reg    <= 24'(count_next);
        end
    end

    assign res.valid      = rvalid_reg;
    assign res.out_valid  = out_valid_reg;
    assign res.out_byte   = out_byte_reg;
    assign res.need_input = need_reg;
    assign res.done_res   = done_reg;
    assign res.error_code = err_reg;
    assign res.byte_count = bcount_reg;

endmodule

[hdl/bpsd_stack_cell.sv]
// ----------------------------------------------------------------------------
// bpsd_stack_cell
// One entry of the shifting expansion stack.
// ----------------------------------------------------------------------------
module bpsd_stack_cell (
    input  logic              clk,
    input  bpsd_pkg::stk_op_t op,
    input  logic [7:0]        from_above,
    input  logic [7:0]        from_below2,
    output logic [7:0]        data
);
    import bpsd_pkg::*;

    logic [7:0] data_reg;
    logic [7:0] data_next;

    always_comb
    begin
        case (op)
            STK_POP:  data_next = from_above;
            STK_PUSH: data_next = from_below2;
            default:  data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[hdl/bpsd_stack.sv]
// ----------------------------------------------------------------------------
// bpsd_stack
// Row of stack cells; the top of stack always sits in cell 0.
// ----------------------------------------------------------------------------
module bpsd_stack (
    input  logic               clk,
    input  bpsd_pkg::stk_ctl_t ctl,
    output logic [7:0]         top
);
    import bpsd_pkg::*;

    logic [7:0] cell_q [STACK_DEPTH];

    genvar i;
    generate
        for (i = 0; i < STACK_DEPTH; i++)
        begin : g_cell
            logic [7:0] above;
            logic [7:0] below2;

            if (i == STACK_DEPTH - 1)
            begin : g_last
                assign above = 8'h00;
            end
            else
            begin : g_mid
                assign above = cell_q[i+1];
            end

            if (i == 0)
            begin : g_c0
                assign below2 = ctl.push_hi;
            end
            else if (i == 1)
            begin : g_c1
                assign below2 = ctl.push_lo;
            end
            else
            begin : g_cn
                assign below2 = cell_q[i-2];
            end

            bpsd_stack_cell u_cell (
                .clk         (clk),
                .op          (ctl.op),
                .from_above  (above),
                .from_below2 (below2),
                .data        (cell_q[i])
            );
        end
    endgenerate

    assign top = cell_q[0];

endmodule

[hdl/bpsd_pair_table.sv]
// ----------------------------------------------------------------------------
// bpsd_pair_table
// Pair table memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bpsd_pair_table #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [15:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [15:0]   rdata
);
    logic [15:0] mem [DEPTH];
    logic [15:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/bpsd_checker.sv]
// ----------------------------------------------------------------------------
// bpsd_assertions
// Port-level checks on the result channel of the decoder.
// ----------------------------------------------------------------------------
module bpsd_assertions (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic        out_valid,
    input logic [7:0]  out_byte,
    input logic        need_input,
    input logic        done_res,
    input logic [1:0]  error_code,
    input logic [23:0] byte_count
);
    import bpsd_pkg::*;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(out_byte) && $stable(byte_count))
        else $error("result changed while stalled");

    a_idle_byte: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !out_valid |-> out_byte == 8'h00)
        else $error("out_byte set without out_valid");

    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && error_code != ERR_NONE |-> done_res && !need_input)
        else $error("error without done");

    a_need_open: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && need_input |-> !done_res)
        else $error("need_input while done");

endmodule

bind byte_pair_stream_decoder bpsd_assertions u_bpsd_assertions (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .out_valid  (res.out_valid),
    .out_byte   (res.out_byte),
    .need_input (res.need_input),
    .done_res   (res.done_res),
    .error_code (res.error_code),
    .byte_count (res.byte_count)
);

[tb/bpsd_checker.sv]
// ----------------------------------------------------------------------------
// bpsd_checker
// Watches the command, result and mode channels of the byte pair decoder,
// predicts one result per accepted item and compares it field by field.
// ----------------------------------------------------------------------------
module bpsd_checker (
    input  logic clk,
    input  logic rst_n,
    bpsd_cmd_if  cmd,
    bpsd_res_if  res,
    bpsd_cfg_if  cfg,
    output int   mismatches,
    output int   pending,
    output int   checked
);
    import bpsd_pkg::*;

    localparam int MAX_PAIRS = 128;

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_TABLE,
        PH_BODY,
        PH_DRAIN,
        PH_DONE,
        PH_ERR_TRUNC,
        PH_ERR_REF,
        PH_ERR_BODY
    } phase_t;

    typedef struct packed {
        logic        out_valid;
        logic [7:0]  out_byte;
        logic        need_input;
        logic        done_res;
        err_t        error_code;
        logic [23:0] byte_count;
    } dec_result_t;

    logic [15:0] pair_words [128];
    logic [7:0]  sym_stack [STACK_DEPTH];
    int unsigned depth;
    int unsigned n_pairs;
    int unsigned fill_pos;      // twice the pair index plus the half
    logic [7:0]  first_half;
    logic [23:0] emitted;
    phase_t      ph;
    logic        mode;
    dec_result_t cur;
    dec_result_t want;
    dec_result_t decoded_q [$];

    function automatic logic file_open();
        return ph == PH_FIRST || ph == PH_TABLE || ph == PH_BODY;
    endfunction

    task automatic restart_file();
        depth = 0;
        n_pairs = 0;
        fill_pos = 0;
        first_half = '0;
        emitted = '0;
        ph = PH_FIRST;
    endtask

    task automatic abort_file(input phase_t code);
        ph = code;
        depth = 0;
    endtask

    task automatic emit_byte(input logic [7:0] c);
        cur.out_valid = 1'b1;
        cur.out_byte = c;
        if (emitted != 24'hFFFFFF)
            emitted++;
    endtask

    // literal goes out, pair reference pushes second half then first half
    task automatic expand_sym(input logic [7:0] c);
        int unsigned slot;
        if (c < 8'd128)
        begin
            emit_byte(c);
        end
        else
        begin
            slot = c - 8'd128;
            if (slot >= n_pairs || depth + 2 > STACK_DEPTH)
            begin
                abort_file(PH_ERR_BODY);
            end
            else
            begin
                sym_stack[depth] = pair_words[slot][7:0];
                sym_stack[depth + 1] = pair_words[slot][15:8];
                depth += 2;
            end
        end
    endtask

    task automatic decode_step(input func_t f, input logic [7:0] c, input logic fs);
        logic        live;
        int unsigned i;
        cur = '0;
        if (fs)
            restart_file();
        live = file_open();
        case (f)
            FN_BYTE:
            begin
                if (live && depth == 0)
                begin
                    if (!mode)
                    begin
                        emit_byte(c);
                        ph = PH_BODY;
                    end
                    else if (ph == PH_FIRST)
                    begin
                        if (c > 8'd127)
                        begin
                            if (c - 8'd128 > MAX_PAIRS)
                            begin
                                abort_file(PH_ERR_REF);
                            end
                            else
                            begin
                                n_pairs = c - 8'd128;
                                fill_pos = 0;
                                ph = (n_pairs == 0) ? PH_BODY : PH_TABLE;
                            end
                        end
                        else
                        begin
                            ph = PH_BODY;
                            expand_sym(c);
                        end
                    end
                    else if (ph == PH_TABLE)
                    begin
                        i = fill_pos >> 1;
                        // a table entry may only name pairs already defined
                        if (c >= 128 + i)
                        begin
                            abort_file(PH_ERR_REF);
                        end
                        else
                        begin
                            if ((fill_pos & 1) == 0)
                                first_half = c;
                            else
                                pair_words[i & 127] = {first_half, c};
                            fill_pos = (fill_pos + 1) & 255;
                            if ((fill_pos & 1) == 0 && (fill_pos >> 1) >= n_pairs)
                                ph = PH_BODY;
                        end
                    end
                    else
                    begin
                        expand_sym(c);
                    end
                end
            end
            FN_TICK:
            begin
                if ((live || ph == PH_DRAIN) && depth > 0)
                begin
                    depth--;
                    expand_sym(sym_stack[depth]);
                    if (ph == PH_DRAIN && depth == 0)
                        ph = PH_DONE;
                end
            end
            FN_EOF:
            begin
                if (live)
                begin
                    if (ph == PH_TABLE && mode)
                        abort_file(PH_ERR_TRUNC);
                    else
                        ph = (depth == 0) ? PH_DONE : PH_DRAIN;
                end
            end
            default: ;
        endcase
        cur.need_input = (depth == 0) && file_open();
        cur.done_res = (ph >= PH_DONE);
        case (ph)
            PH_ERR_TRUNC: cur.error_code = ERR_TRUNC;
            PH_ERR_REF:   cur.error_code = ERR_REF;
            PH_ERR_BODY:  cur.error_code = ERR_BODY;
            default:      cur.error_code = ERR_NONE;
        endcase
        cur.byte_count = emitted;
        decoded_q.push_back(cur);
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [23:0] got,
                               input logic [23:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                      checked, name, got, exp_val));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_file();
            mode = 1'b1;
            decoded_q.delete();
            mismatches = 0;
            checked = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                mode = cfg.compressed_mode;
            if (cmd.valid && cmd.ready)
                decode_step(func_t'(cmd.func), cmd.data_byte, cmd.file_start);
            if (res.valid && res.ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    report_mismatch($sformatf("result with no item waiting, byte %0h",
                                              res.out_byte));
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("out_valid", res.out_valid, want.out_valid);
                    check_field("out_byte", res.out_byte, want.out_byte);
                    check_field("need_input", res.need_input, want.need_input);
                    check_field("done_res", res.done_res, want.done_res);
                    check_field("error_code", res.error_code, want.error_code);
                    check_field("byte_count", res.byte_count, want.byte_count);
                    checked++;
                end
            end
            pending <= decoded_q.size();
        end
    end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives compressed files, broken files and bypass streams into the byte
// pair decoder with random gaps and stalls; the checker judges every result.
// ----------------------------------------------------------------------------
module tb_top;
    import bpsd_pkg::*;

    localparam int LIMIT = 500000;

    logic clk = 1'b0;
    logic rst_n;
    bit   calm = 1'b0;      // no gaps on either side while set
    int   useful = 0;
    int   files = 0;
    int   cycles = 0;
    int   mismatches;
    int   pending;
    int   checked;
    int   file_ticks [128]; // ticks needed to drain one pair of the current file

    bpsd_cmd_if cmd_ch ();
    bpsd_res_if res_ch ();
    bpsd_cfg_if cfg_ch ();

    byte_pair_stream_decoder uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    bpsd_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .res        (res_ch),
        .cfg        (cfg_ch),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_ch.ready <= calm || ($urandom_range(0, 99) >= 8);
        end
    end

    task automatic send_item(input func_t f, input logic [7:0] b, input logic fs,
                             input bit live);
        while (!calm && $urandom_range(0, 99) < 8)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.func <= f;
        cmd_ch.data_byte <= b;
        cmd_ch.file_start <= fs;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        if (live)
            useful++;
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic write_mode(input logic v);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.compressed_mode <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // literal, or a reference to an earlier pair that drains quickly
    function automatic logic [7:0] pick_half(input int i);
        int j;
        if (i > 0 && $urandom_range(0, 99) < 45)
        begin
            j = $urandom_range(0, i - 1);
            if (file_ticks[j] <= 14)
                return 8'(128 + j);
        end
        return 8'($urandom_range(0, 127));
    endfunction

    task automatic run_file(input int n, input bit headerless, input bit chain);
        logic [7:0] hi;
        logic [7:0] lo;
        int         j;
        int         t;
        int         r;
        int         body_len;
        bit         drained;
        files++;
        // new file announced on a tick or no-op ahead of the header
        if ($urandom_range(0, 9) == 0)
        begin
            send_item($urandom_range(0, 1) ? FN_TICK : FN_NOP, 8'($urandom), 1'b1, 1'b1);
            if (headerless)
                send_item(FN_BYTE, 8'($urandom_range(0, 127)), 1'b0, 1'b1);
            else
                send_item(FN_BYTE, 8'(128 + n), 1'b0, 1'b1);
        end
        else if (headerless)
        begin
            send_item(FN_BYTE, 8'($urandom_range(0, 127)), 1'b1, 1'b1);
        end
        else
        begin
            send_item(FN_BYTE, 8'(128 + n), 1'b1, 1'b1);
        end
        if (headerless)
            n = 0;

        for (int i = 0; i < n; i++)
        begin
            if (!chain && $urandom_range(0, 99) < 2)
            begin
                // broken table: bad reference in either half, or early end
                if ($urandom_range(0, 1))
                    send_item(FN_BYTE, pick_half(i), 1'b0, 1'b1);
                if ($urandom_range(0, 1))
                    send_item(FN_BYTE, 8'(128 + i + $urandom_range(0, 127 - i)), 1'b0, 1'b1);
                else
                    send_item(FN_EOF, 8'($urandom), 1'b0, 1'b1);
                send_item(FN_TICK, 8'($urandom), 1'b0, 1'b0);
                return;
            end
            if (chain)
            begin
                hi = (i > 0) ? 8'(127 + i) : 8'($urandom_range(0, 127));
                lo = 8'($urandom_range(0, 127));
            end
            else
            begin
                hi = pick_half(i);
                lo = pick_half(i);
            end
            file_ticks[i] = 2 + (hi[7] ? file_ticks[hi[6:0]] : 0)
                              + (lo[7] ? file_ticks[lo[6:0]] : 0);
            send_item(FN_BYTE, hi, 1'b0, 1'b1);
            send_item(FN_BYTE, lo, 1'b0, 1'b1);
        end

        body_len = chain ? 1 : $urandom_range(2, 24);
        for (int k = 0; k < body_len; k++)
        begin
            r = chain ? 50 : $urandom_range(0, 99);
            if (r < 2)
            begin
                // unknown pair in the body
                send_item(FN_BYTE, 8'(128 + n + $urandom_range(0, 127 - n)), 1'b0, 1'b1);
                send_item(FN_EOF, 8'($urandom), 1'b0, 1'b0);
                return;
            end
            else if (r < 7)
            begin
                send_item($urandom_range(0, 1) ? FN_TICK : FN_NOP, 8'($urandom), 1'b0, 1'b1);
            end
            else if (n > 0 && r < 55)
            begin
                j = chain ? n - 1 : $urandom_range(0, n - 1);
                send_item(FN_BYTE, 8'(128 + j), 1'b0, 1'b1);
                t = file_ticks[j];
                drained = ($urandom_range(0, 99) < 6);
                for (int q = 0; q < t; q++)
                begin
                    // abandoned mid-expansion; the next file start clears it
                    if (!chain && $urandom_range(0, 199) == 0)
                        return;
                    if ($urandom_range(0, 99) < 3)
                        send_item(FN_BYTE, 8'($urandom), 1'b0, 1'b0);
                    if (drained && q == t / 2)
                        send_item(FN_EOF, 8'($urandom), 1'b0, 1'b1);
                    send_item(FN_TICK, 8'($urandom), 1'b0, 1'b1);
                end
                if (drained)
                begin
                    send_item(FN_TICK, 8'($urandom), 1'b0, 1'b0);
                    return;
                end
            end
            else
            begin
                send_item(FN_BYTE, 8'($urandom_range(0, 127)), 1'b0, 1'b1);
            end
        end
        send_item(FN_EOF, 8'($urandom), 1'b0, 1'b1);
        if ($urandom_range(0, 4) == 0)
            send_item(func_t'($urandom_range(0, 3)), 8'($urandom), 1'b0, 1'b0);
    endtask

    task automatic run_plain_file();
        int r;
        files++;
        send_item(FN_BYTE, 8'($urandom), 1'b1, 1'b1);
        repeat ($urandom_range(3, 30))
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                send_item(FN_TICK, 8'($urandom), 1'b0, 1'b1);
            else if (r < 13)
                send_item(FN_NOP, 8'($urandom), 1'b0, 1'b1);
            else
                send_item(FN_BYTE, 8'($urandom), 1'b0, 1'b1);
        end
        send_item(FN_EOF, 8'($urandom), 1'b0, 1'b1);
        if ($urandom_range(0, 3) == 0)
            send_item(FN_BYTE, 8'($urandom), 1'b0, 1'b0);
    endtask

    task automatic run_compressed_until(input int goal);
        while (useful < goal)
        begin
            calm = (useful >= 600 && useful < 850);
            if ($urandom_range(0, 6) == 0)
                run_file(0, 1'b1, 1'b0);
            else if ($urandom_range(0, 99) < 8)
                run_file($urandom_range(7, 40), 1'b0, 1'b0);
            else
                run_file($urandom_range(0, 6), 1'b0, 1'b0);
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.func <= FN_NOP;
        cmd_ch.data_byte <= 8'h00;
        cmd_ch.file_start <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.compressed_mode <= 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // headerless file, extreme literals, idle tick, no-op, end, then ignored
        send_item(FN_BYTE, 8'h00, 1'b1, 1'b1);
        send_item(FN_BYTE, 8'h7F, 1'b0, 1'b1);
        send_item(FN_TICK, 8'hFF, 1'b0, 1'b1);
        send_item(FN_NOP, 8'hFF, 1'b0, 1'b1);
        send_item(FN_EOF, 8'h00, 1'b0, 1'b1);
        send_item(FN_BYTE, 8'h41, 1'b0, 1'b0);
        // empty table, then a pair that does not exist
        send_item(FN_BYTE, 8'h80, 1'b1, 1'b1);
        send_item(FN_BYTE, 8'h80, 1'b0, 1'b1);
        send_item(FN_TICK, 8'h00, 1'b0, 1'b0);
        // table entry naming itself, then one naming a later pair
        send_item(FN_BYTE, 8'h81, 1'b1, 1'b1);
        send_item(FN_BYTE, 8'h80, 1'b0, 1'b1);
        send_item(FN_BYTE, 8'h82, 1'b1, 1'b1);
        send_item(FN_BYTE, 8'h81, 1'b0, 1'b1);
        // end of file inside the table
        send_item(FN_BYTE, 8'h82, 1'b1, 1'b1);
        send_item(FN_BYTE, 8'h41, 1'b0, 1'b1);
        send_item(FN_EOF, 8'h00, 1'b0, 1'b1);
        // nested pair, byte while expanding, end of file while expanding
        send_item(FN_BYTE, 8'h82, 1'b1, 1'b1);
        send_item(FN_BYTE, 8'h41, 1'b0, 1'b1);
        send_item(FN_BYTE, 8'h42, 1'b0, 1'b1);
        send_item(FN_BYTE, 8'h80, 1'b0, 1'b1);
        send_item(FN_BYTE, 8'h43, 1'b0, 1'b1);
        send_item(FN_BYTE, 8'h81, 1'b0, 1'b1);
        send_item(FN_BYTE, 8'h55, 1'b0, 1'b0);
        send_item(FN_TICK, 8'h00, 1'b0, 1'b1);
        send_item(FN_EOF, 8'h00, 1'b0, 1'b1);
        send_item(FN_BYTE, 8'h30, 1'b0, 1'b0);
        repeat (3) send_item(FN_TICK, 8'h00, 1'b0, 1'b1);
        send_item(FN_TICK, 8'h00, 1'b0, 1'b0);
        // bypass switched on halfway through a table
        send_item(FN_BYTE, 8'h83, 1'b1, 1'b1);
        send_item(FN_BYTE, 8'h41, 1'b0, 1'b1);
        write_mode(1'b0);
        send_item(FN_BYTE, 8'hC5, 1'b0, 1'b1);
        send_item(FN_TICK, 8'h00, 1'b0, 1'b1);
        send_item(FN_EOF, 8'h00, 1'b0, 1'b1);
        write_mode(1'b1);

        // deepest nesting: 127 pairs, each built on the one before
        run_file(127, 1'b0, 1'b1);
        run_compressed_until(1100);
        write_mode(1'b0);
        while (useful < 1300)
            run_plain_file();
        write_mode(1'b1);
        run_compressed_until(1700);

        wait_drained();
        repeat (8) @(posedge clk);
        $display("Sent %0d items in %0d files over compressed and bypass modes", useful, files);
        $display("Checked %0d results, tables up to 127 pairs, nesting to full depth", checked);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
